>>> hw/rtl/bcpr_pkg.sv
package bcpr_pkg;

  // Default widths of the feedback samples and of the duty value.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF   = 16;

  // Fixed field widths on the ports.
  localparam int SAMPLE_W   = 12;
  localparam int DUTY_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int CMP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Result beat layout, lowest bit first.
  localparam int OUT_STEP_BIT  = 0;
  localparam int OUT_ON_BIT    = 1;
  localparam int OUT_PWM_BIT   = 2;
  localparam int OUT_DUTY_LSB  = 3;
  localparam int OUT_TRIP_BIT  = OUT_DUTY_LSB + DUTY_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTROL_PERIOD    = 3'd0,
    CFG_DUTY_MAX          = 3'd1,
    CFG_DUTY_INITIAL      = 3'd2,
    CFG_OVERCURRENT_LIMIT = 3'd3,
    CFG_BAND_LOW_VOLTAGE  = 3'd4,
    CFG_BAND_HIGH_VOLTAGE = 3'd5
  } cfg_reg_e;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] RST_CONTROL_PERIOD    = 8'd10;
  localparam logic [DUTY_W-1:0]   RST_DUTY_MAX          = 16'd255;
  localparam logic [DUTY_W-1:0]   RST_DUTY_INITIAL      = 16'd0;
  localparam logic [SAMPLE_W-1:0] RST_OVERCURRENT_LIMIT = 12'd600;
  localparam logic [SAMPLE_W-1:0] RST_BAND_LOW_VOLTAGE  = 12'd150;
  localparam logic [SAMPLE_W-1:0] RST_BAND_HIGH_VOLTAGE = 12'd250;

  // Input item command codes.
  typedef enum logic {
    CMD_TICK       = 1'b0,
    CMD_SET_ENABLE = 1'b1
  } cmd_e;

  // Voltage bands.
  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_e;

  // One accepted input beat.
  typedef struct packed {
    cmd_e                command;
    logic                enable_value;
    logic [SAMPLE_W-1:0] voltage_sample;
    logic [SAMPLE_W-1:0] current_sample;
  } in_item_t;

  // Lower edge of the current window for each band.
  function automatic logic [SAMPLE_W-1:0] win_lo(input band_e band);
    logic [SAMPLE_W-1:0] v;
    unique case (band)
      BAND_LOW:  v = 12'd210;
      BAND_MID:  v = 12'd300;
      BAND_HIGH: v = 12'd340;
      default:   v = 12'd340;
    endcase
    return v;
  endfunction

  // Upper edge of the current window for each band.
  function automatic logic [SAMPLE_W-1:0] win_hi(input band_e band);
    logic [SAMPLE_W-1:0] v;
    unique case (band)
      BAND_LOW:  v = 12'd230;
      BAND_MID:  v = 12'd320;
      BAND_HIGH: v = 12'd360;
      default:   v = 12'd360;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/banded_current_pwm_regulator_core.sv
// Banded current PWM regulator.
//
// Input stream (s_axis_*): one beat per item. tuser selects the item kind:
// a millisecond tick carrying voltage and current samples, or a set-enable
// command. Every tick advances a counter; when it reaches control_period a
// control step runs, nudging the duty one count toward the current window of
// the band picked by the voltage sample (if disabled: drive off, initial duty).
// Output stream (m_axis_*): exactly one result beat per input beat, in order,
// reporting the drive, PWM and duty state after that item.
// Configuration: cfg_we_i writes register cfg_idx_i at the clock edge; write
// only while no beat is in flight.
// A beat passes an input register, then the control logic into the result
// register. Throughput is one beat per cycle while the receiver takes
// results; the whole control step is a single compare-and-adjust pass.
// Reset clears the pipeline, the tick counter, enable, drive and PWM state and
// loads the register defaults. When the receiver stalls, the result holds and
// one more input beat is taken into the input register; then s_axis_tready
// drops until the result is taken.
module banded_current_pwm_regulator_core #(
  parameter int SAMPLE_BITS = bcpr_pkg::SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = bcpr_pkg::DUTY_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [bcpr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcpr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: enable_value[0], voltage_sample[12:1], current_sample[24:13], zeros.
  input  logic [bcpr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: command[0].
  input  logic                                 s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: step_done[0], output_on[1], pwm_running[2], duty[18:3],
  // overcurrent_trip[19], zeros.
  output logic [bcpr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int SampleW = bcpr_pkg::SAMPLE_W;
  localparam int DutyW   = bcpr_pkg::DUTY_W;
  localparam int PeriodW = bcpr_pkg::PERIOD_W;
  localparam int CmpW    = bcpr_pkg::CMP_W;
  localparam int PadW    = bcpr_pkg::OUT_TDATA_W - bcpr_pkg::OUT_TRIP_BIT - 1;

  // Configuration registers.
  logic [PeriodW-1:0]   period_q;
  logic [DUTY_BITS-1:0] duty_max_q;
  logic [DUTY_BITS-1:0] duty_init_q;
  logic [SampleW-1:0]   oc_limit_q;
  logic [SampleW-1:0]   band_lo_q;
  logic [SampleW-1:0]   band_hi_q;

  // Regulator state.
  logic [PeriodW-1:0]   tick_q, tick_d;
  logic                 enable_q, enable_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 drive_q, drive_d;
  logic                 pwm_q, pwm_d;

  // Pipeline registers.
  logic                 in_valid_q;
  bcpr_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  logic [bcpr_pkg::OUT_TDATA_W-1:0] out_q, out_d;

  logic                 advance;
  logic                 fire;
  logic                 step_done;
  logic                 trip;
  logic [PeriodW-1:0]   tick_inc;
  logic [CmpW-1:0]      volts;
  logic [CmpW-1:0]      amps;
  bcpr_pkg::band_e      band;
  logic [DUTY_BITS-1:0] duty_raised;

  // Register writes from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= bcpr_pkg::RST_CONTROL_PERIOD;
      duty_max_q  <= DUTY_BITS'(bcpr_pkg::RST_DUTY_MAX);
      duty_init_q <= DUTY_BITS'(bcpr_pkg::RST_DUTY_INITIAL);
      oc_limit_q  <= bcpr_pkg::RST_OVERCURRENT_LIMIT;
      band_lo_q   <= bcpr_pkg::RST_BAND_LOW_VOLTAGE;
      band_hi_q   <= bcpr_pkg::RST_BAND_HIGH_VOLTAGE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcpr_pkg::CFG_CONTROL_PERIOD:    period_q    <= cfg_data_i[PeriodW-1:0];
        bcpr_pkg::CFG_DUTY_MAX:          duty_max_q  <= DUTY_BITS'(cfg_data_i);
        bcpr_pkg::CFG_DUTY_INITIAL:      duty_init_q <= DUTY_BITS'(cfg_data_i);
        bcpr_pkg::CFG_OVERCURRENT_LIMIT: oc_limit_q  <= cfg_data_i[SampleW-1:0];
        bcpr_pkg::CFG_BAND_LOW_VOLTAGE:  band_lo_q   <= cfg_data_i[SampleW-1:0];
        bcpr_pkg::CFG_BAND_HIGH_VOLTAGE: band_hi_q   <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or taken.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command        <= bcpr_pkg::cmd_e'(s_axis_tuser);
      in_q.enable_value   <= s_axis_tdata[0];
      in_q.voltage_sample <= s_axis_tdata[SampleW:1];
      in_q.current_sample <= s_axis_tdata[2*SampleW:SampleW+1];
    end
  end

  // Samples trimmed to the configured sample width, widened for compares.
  assign volts = CmpW'(SAMPLE_BITS'(in_q.voltage_sample));
  assign amps  = CmpW'(SAMPLE_BITS'(in_q.current_sample));

  // Band selection; the low-band test wins when thresholds are crossed.
  always_comb begin
    if (volts < CmpW'(band_lo_q)) begin
      band = bcpr_pkg::BAND_LOW;
    end else if (volts < CmpW'(band_hi_q)) begin
      band = bcpr_pkg::BAND_MID;
    end else begin
      band = bcpr_pkg::BAND_HIGH;
    end
  end

  assign tick_inc = (tick_q < period_q) ? tick_q + 1'b1 : tick_q;

  // Control step: one pass over the item held in the input register.
  always_comb begin
    tick_d      = tick_q;
    enable_d    = enable_q;
    duty_d      = duty_q;
    drive_d     = drive_q;
    pwm_d       = pwm_q;
    step_done   = 1'b0;
    trip        = 1'b0;
    duty_raised = duty_q;
    unique case (in_q.command)
      bcpr_pkg::CMD_SET_ENABLE: begin
        enable_d = in_q.enable_value;
      end
      bcpr_pkg::CMD_TICK: begin
        tick_d = tick_inc;
        if (tick_inc >= period_q) begin
          tick_d    = '0;
          step_done = 1'b1;
          if (!enable_q) begin
            drive_d = 1'b0;
            pwm_d   = 1'b0;
            duty_d  = duty_init_q;
          end else begin
            drive_d = 1'b1;
            pwm_d   = 1'b1;
            // Raise below the window, then lower above it.
            if (amps < CmpW'(bcpr_pkg::win_lo(band)) && duty_q < duty_max_q) begin
              duty_raised = duty_q + 1'b1;
            end
            duty_d = duty_raised;
            if (amps > CmpW'(bcpr_pkg::win_hi(band)) && duty_raised != '0) begin
              duty_d = duty_raised - 1'b1;
            end
            // Zero duty with excess current cuts the drive.
            if (duty_d == '0 && amps > CmpW'(oc_limit_q)) begin
              drive_d = 1'b0;
              trip    = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Pack the result beat.
  always_comb begin
    out_d = {{PadW{1'b0}}, trip, DutyW'(duty_d), pwm_d, drive_d, step_done};
  end

  // State and result register update once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      enable_q    <= 1'b0;
      duty_q      <= DUTY_BITS'(bcpr_pkg::RST_DUTY_INITIAL);
      drive_q     <= 1'b0;
      pwm_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        tick_q   <= tick_d;
        enable_q <= enable_d;
        duty_q   <= duty_d;
        drive_q  <= drive_d;
        pwm_q    <= pwm_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

>>> hw/rtl/bcpr_checker.sv
module bcpr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bcpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                       step_done;
  logic                       output_on;
  logic                       pwm_running;
  logic                       trip;
  logic [bcpr_pkg::DUTY_W-1:0] duty;

  assign step_done   = m_axis_tdata[bcpr_pkg::OUT_STEP_BIT];
  assign output_on   = m_axis_tdata[bcpr_pkg::OUT_ON_BIT];
  assign pwm_running = m_axis_tdata[bcpr_pkg::OUT_PWM_BIT];
  assign trip        = m_axis_tdata[bcpr_pkg::OUT_TRIP_BIT];
  assign duty        = m_axis_tdata[bcpr_pkg::OUT_TRIP_BIT-1:bcpr_pkg::OUT_DUTY_LSB];

  // A stalled result beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The drive is never on while the PWM is stopped.
  a_drive_needs_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && output_on |-> pwm_running)
    else $error("drive on with PWM stopped");

  // An overcurrent trip only comes from an enabled step at zero duty.
  a_trip_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trip |-> step_done && pwm_running && !output_on && duty == '0)
    else $error("overcurrent trip with inconsistent state");

  // A result appearing on an empty output follows an input beat accepted through the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without matching input beat");

endmodule

bind banded_current_pwm_regulator_core bcpr_checker u_bcpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
